@@ design/cc20_pkg.sv @@
package cc20_pkg;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_cfg_data;
    typedef logic [2:0]  t_cfg_addr;
    typedef logic [2:0]  t_bytes;

    // register map of the configuration port
    typedef enum logic [2:0] {
        CFG_KEY_0_7    = 3'd0,
        CFG_KEY_8_15   = 3'd1,
        CFG_KEY_16_23  = 3'd2,
        CFG_KEY_24_31  = 3'd3,
        CFG_NONCE_0_7  = 3'd4,
        CFG_NONCE_8_11 = 3'd5,
        CFG_INIT_CTR   = 3'd6
    } t_cfg_idx;

    // the four add-xor-rotate steps of one quarter-round
    typedef enum logic [1:0] {
        ARX_AB_D16 = 2'd0,
        ARX_CD_B12 = 2'd1,
        ARX_AB_D8  = 2'd2,
        ARX_CD_B7  = 2'd3
    } t_arx_step;

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    localparam int NUM_HALF_ROUNDS = 20;

    localparam t_bytes BYTES_NONE  = 3'd0;
    localparam t_bytes BYTES_ONE   = 3'd1;
    localparam t_bytes BYTES_TWO   = 3'd2;
    localparam t_bytes BYTES_THREE = 3'd3;
    localparam t_bytes BYTES_FULL  = 3'd4;

endpackage

@@ design/cc20_in_if.sv @@
interface cc20_in_if;
    logic                 valid;
    logic                 ready;
    cc20_pkg::t_word      data_word;
    cc20_pkg::t_bytes     byte_count;
    logic                 first_of_message;
    logic                 last_of_message;

    modport source (
        output valid, data_word, byte_count, first_of_message, last_of_message,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_of_message, last_of_message,
        output ready
    );
endinterface

@@ design/cc20_out_if.sv @@
interface cc20_out_if;
    logic                 valid;
    logic                 ready;
    cc20_pkg::t_word      result_word;
    cc20_pkg::t_bytes     result_bytes;
    logic                 result_last;

    modport source (
        output valid, result_word, result_bytes, result_last,
        input  ready
    );
    modport sink (
        input  valid, result_word, result_bytes, result_last,
        output ready
    );
endinterface

@@ design/cc20_cfg_if.sv @@
interface cc20_cfg_if;
    logic                  valid;
    logic                  ready;
    cc20_pkg::t_cfg_addr   index;
    cc20_pkg::t_cfg_data   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ design/cc20_arx.sv @@
module cc20_arx (
    input  cc20_pkg::t_arx_step i_step,
    input  cc20_pkg::t_word     i_a,
    input  cc20_pkg::t_word     i_b,
    input  cc20_pkg::t_word     i_c,
    input  cc20_pkg::t_word     i_d,
    output cc20_pkg::t_word     o_a,
    output cc20_pkg::t_word     o_b,
    output cc20_pkg::t_word     o_c,
    output cc20_pkg::t_word     o_d
);

    logic            ab_step;
    cc20_pkg::t_word sum;
    cc20_pkg::t_word mix;
    cc20_pkg::t_word rot;

    always_comb begin
        ab_step = (i_step == cc20_pkg::ARX_AB_D16) || (i_step == cc20_pkg::ARX_AB_D8);
        // one shared adder: a+b or c+d
        sum     = ab_step ? (i_a + i_b) : (i_c + i_d);
        mix     = (ab_step ? i_d : i_b) ^ sum;
        case (i_step)
            cc20_pkg::ARX_AB_D16: begin
                rot = {mix[15:0], mix[31:16]};
            end
            cc20_pkg::ARX_CD_B12: begin
                rot = {mix[19:0], mix[31:20]};
            end
            cc20_pkg::ARX_AB_D8: begin
                rot = {mix[23:0], mix[31:24]};
            end
            cc20_pkg::ARX_CD_B7: begin
                rot = {mix[24:0], mix[31:25]};
            end
            default: begin
                rot = mix;
            end
        endcase
        o_a = ab_step ? sum : i_a;
        o_d = ab_step ? rot : i_d;
        o_c = ab_step ? i_c : sum;
        o_b = ab_step ? i_b : rot;
    end

endmodule

@@ design/chacha20_stream_cipher.sv @@
// chacha20 stream cipher, 20 rounds, 96-bit nonce, 32-bit block counter. each input item is
// one little-endian data word that leaves xored with the matching keystream word; bytes above
// byte_count are zeroed (a count of 0 or above 4 means a full word). key, nonce and initial
// counter are for the user to write on the configuration port only while the block is idle;
// the block itself does not enforce it. the first word of every 64-byte block runs the block
// function: the state sits in a 4x4 register array and four add-xor-rotate lanes (columns,
// then diagonals) each do one step per cycle through the 20 rounds; then the input state is
// added back in, one row at a time, and the word goes to the output step. every other word
// goes from acceptance straight to the output step. a new word is only taken once the last
// has left for the output register; a finished result waits there, and the next item is
// taken while it waits. after reset no clearing pass is needed.
module chacha20_stream_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cc20_cfg_if.sink   i_cfg,
    cc20_in_if.sink    i_data,
    cc20_out_if.source o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    // configuration registers
    cc20_pkg::t_cfg_data r_key_0_7;
    cc20_pkg::t_cfg_data r_key_8_15;
    cc20_pkg::t_cfg_data r_key_16_23;
    cc20_pkg::t_cfg_data r_key_24_31;
    cc20_pkg::t_cfg_data r_nonce_0_7;
    cc20_pkg::t_word     r_nonce_8_11;
    cc20_pkg::t_word     r_init_ctr;

    // sequencer and stream position
    t_state          r_state;
    logic [1:0]      r_step;
    logic [4:0]      r_half;
    logic [3:0]      r_pos;
    cc20_pkg::t_word r_ctr;

    // latched item
    cc20_pkg::t_word  r_data;
    cc20_pkg::t_bytes r_cnt;
    logic             r_last;

    // output register
    logic             r_ov;
    cc20_pkg::t_word  r_res_word;
    cc20_pkg::t_bytes r_res_bytes;
    logic             r_res_last;

    // working state, row-major: word 4*row+col; holds the keystream once the block is done
    cc20_pkg::t_word r_ws [4][4];
    cc20_pkg::t_word n_ws [4][4];

    cc20_pkg::t_word  init_w [4][4];
    cc20_pkg::t_word  lane_a [4];
    cc20_pkg::t_word  lane_b [4];
    cc20_pkg::t_word  lane_c [4];
    cc20_pkg::t_word  lane_d [4];

    logic             in_acc;
    logic             diag;
    logic [3:0]       pos_eff;
    cc20_pkg::t_word  ctr_eff;
    cc20_pkg::t_word  ctr_sel;
    cc20_pkg::t_bytes cnt_norm;
    cc20_pkg::t_word  ks_word;
    cc20_pkg::t_word  byte_mask;
    logic             emit_go;

    assign i_cfg.ready  = 1'b1;
    assign i_data.ready = (r_state == ST_IDLE);
    assign in_acc       = i_data.valid && (r_state == ST_IDLE);

    assign o_result.valid        = r_ov;
    assign o_result.result_word  = r_res_word;
    assign o_result.result_bytes = r_res_bytes;
    assign o_result.result_last  = r_res_last;

    // odd half-rounds work on the diagonals
    assign diag = r_half[0];

    // a first word restarts the message at the initial counter
    assign pos_eff = i_data.first_of_message ? 4'd0 : r_pos;
    assign ctr_eff = i_data.first_of_message ? r_init_ctr : r_ctr;
    // the counter held in r_ctr is the one of the block being built
    assign ctr_sel = (r_state == ST_IDLE) ? ctr_eff : r_ctr;

    always_comb begin
        if ((i_data.byte_count == cc20_pkg::BYTES_NONE)
                || (i_data.byte_count > cc20_pkg::BYTES_FULL)) begin
            cnt_norm = cc20_pkg::BYTES_FULL;
        end else begin
            cnt_norm = i_data.byte_count;
        end
    end

    // block function input: constants, key, counter, nonce
    always_comb begin
        init_w[0][0] = cc20_pkg::SIGMA_0;
        init_w[0][1] = cc20_pkg::SIGMA_1;
        init_w[0][2] = cc20_pkg::SIGMA_2;
        init_w[0][3] = cc20_pkg::SIGMA_3;
        init_w[1][0] = r_key_0_7[31:0];
        init_w[1][1] = r_key_0_7[63:32];
        init_w[1][2] = r_key_8_15[31:0];
        init_w[1][3] = r_key_8_15[63:32];
        init_w[2][0] = r_key_16_23[31:0];
        init_w[2][1] = r_key_16_23[63:32];
        init_w[2][2] = r_key_24_31[31:0];
        init_w[2][3] = r_key_24_31[63:32];
        init_w[3][0] = ctr_sel;
        init_w[3][1] = r_nonce_0_7[31:0];
        init_w[3][2] = r_nonce_0_7[63:32];
        init_w[3][3] = r_nonce_8_11;
    end

    // four quarter-round lanes; lane j takes column j, or the diagonal starting at column j
    for (genvar j = 0; j < 4; j++) begin : g_lane
        localparam int JB = (j + 1) % 4;
        localparam int JC = (j + 2) % 4;
        localparam int JD = (j + 3) % 4;

        cc20_pkg::t_word tap_b;
        cc20_pkg::t_word tap_c;
        cc20_pkg::t_word tap_d;

        assign tap_b = diag ? r_ws[1][JB] : r_ws[1][j];
        assign tap_c = diag ? r_ws[2][JC] : r_ws[2][j];
        assign tap_d = diag ? r_ws[3][JD] : r_ws[3][j];

        cc20_arx u_arx (
            .i_step (cc20_pkg::t_arx_step'(r_step)),
            .i_a    (r_ws[0][j]),
            .i_b    (tap_b),
            .i_c    (tap_c),
            .i_d    (tap_d),
            .o_a    (lane_a[j]),
            .o_b    (lane_b[j]),
            .o_c    (lane_c[j]),
            .o_d    (lane_d[j])
        );
    end

    // next working state
    always_comb begin
        n_ws = r_ws;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (pos_eff == 4'd0)) begin
                    n_ws = init_w;
                end
            end
            ST_ROUND: begin
                for (int j = 0; j < 4; j++) begin
                    n_ws[0][j] = lane_a[j];
                    if (diag) begin
                        n_ws[1][2'(j + 1)] = lane_b[j];
                        n_ws[2][2'(j + 2)] = lane_c[j];
                        n_ws[3][2'(j + 3)] = lane_d[j];
                    end else begin
                        n_ws[1][j] = lane_b[j];
                        n_ws[2][j] = lane_c[j];
                        n_ws[3][j] = lane_d[j];
                    end
                end
            end
            ST_FINAL: begin
                // add the input state back in, one row per cycle
                for (int j = 0; j < 4; j++) begin
                    n_ws[r_step][j] = r_ws[r_step][j] + init_w[r_step][j];
                end
            end
            default: begin
                n_ws = r_ws;
            end
        endcase
    end

    // output word
    assign ks_word = r_ws[r_pos[3:2]][r_pos[1:0]];

    always_comb begin
        case (r_cnt)
            cc20_pkg::BYTES_ONE: begin
                byte_mask = 32'h0000_00ff;
            end
            cc20_pkg::BYTES_TWO: begin
                byte_mask = 32'h0000_ffff;
            end
            cc20_pkg::BYTES_THREE: begin
                byte_mask = 32'h00ff_ffff;
            end
            default: begin
                byte_mask = 32'hffff_ffff;
            end
        endcase
    end

    // the result goes out once the output register is free or being emptied
    assign emit_go = (r_state == ST_EMIT) && (!r_ov || o_result.ready);

    always_ff @(posedge i_clk) begin
        r_ws <= n_ws;

        if (!i_rst_n) begin
            r_key_0_7    <= '0;
            r_key_8_15   <= '0;
            r_key_16_23  <= '0;
            r_key_24_31  <= '0;
            r_nonce_0_7  <= '0;
            r_nonce_8_11 <= '0;
            r_init_ctr   <= '0;
            r_state      <= ST_IDLE;
            r_step       <= 2'd0;
            r_half       <= 5'd0;
            r_pos        <= 4'd0;
            r_ctr        <= '0;
            r_ov         <= 1'b0;
        end else begin
            // configuration writes; unknown indexes are dropped
            if (i_cfg.valid) begin
                case (cc20_pkg::t_cfg_idx'(i_cfg.index))
                    cc20_pkg::CFG_KEY_0_7: begin
                        r_key_0_7 <= i_cfg.data;
                    end
                    cc20_pkg::CFG_KEY_8_15: begin
                        r_key_8_15 <= i_cfg.data;
                    end
                    cc20_pkg::CFG_KEY_16_23: begin
                        r_key_16_23 <= i_cfg.data;
                    end
                    cc20_pkg::CFG_KEY_24_31: begin
                        r_key_24_31 <= i_cfg.data;
                    end
                    cc20_pkg::CFG_NONCE_0_7: begin
                        r_nonce_0_7 <= i_cfg.data;
                    end
                    cc20_pkg::CFG_NONCE_8_11: begin
                        r_nonce_8_11 <= i_cfg.data[31:0];
                    end
                    cc20_pkg::CFG_INIT_CTR: begin
                        r_init_ctr <= i_cfg.data[31:0];
                    end
                    default: begin
                    end
                endcase
            end

            // output register fills on a new result, empties when taken
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_data <= i_data.data_word;
                        r_cnt  <= cnt_norm;
                        r_last <= i_data.last_of_message;
                        r_pos  <= pos_eff;
                        r_ctr  <= ctr_eff;
                        r_step <= 2'd0;
                        r_half <= 5'd0;
                        // word 0 of a block needs a fresh keystream block
                        if (pos_eff == 4'd0) begin
                            r_state <= ST_ROUND;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_ROUND: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        if (r_half == 5'(cc20_pkg::NUM_HALF_ROUNDS - 1)) begin
                            r_half  <= 5'd0;
                            r_state <= ST_FINAL;
                        end else begin
                            r_half <= r_half + 5'd1;
                        end
                    end
                end
                ST_FINAL: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_ctr   <= r_ctr + 32'd1;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_res_word  <= (r_data ^ ks_word) & byte_mask;
                        r_res_bytes <= r_cnt;
                        r_res_last  <= r_last;
                        // end of message rewinds to the initial counter
                        if (r_last) begin
                            r_pos <= 4'd0;
                            r_ctr <= r_init_ctr;
                        end else begin
                            r_pos <= r_pos + 4'd1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a first word always starts at word 0 of a block
    a_first_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.first_of_message) |=> (r_pos == 4'd0))
        else $error("first word did not restart the block position");

    // the counter moves on by one when a block is finished
    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL && r_step == 2'd3) |=> (r_ctr == $past(r_ctr) + 32'd1))
        else $error("block counter did not advance after a block");

    // a result appears only out of the output step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == ST_EMIT))
        else $error("result raised outside the output step");

    // the round counter stays within the 20 rounds
    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_half < 5'(cc20_pkg::NUM_HALF_ROUNDS)))
        else $error("round counter out of range");
`endif

endmodule
